// ----- src/bst_insert_depth_accumulator_macros.svh -----
// Assertion macros for the BST insertion-depth block.
`ifndef BST_INSERT_DEPTH_ACCUMULATOR_MACROS_SVH
`define BST_INSERT_DEPTH_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BSTID_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define BSTID_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BSTID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BSTID_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define BSTID_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BSTID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/bstid_pkg.sv -----
// Shared constants and controller/datapath interface types.
`default_nettype none
package bstid_pkg;
	localparam int KEY_W       = 11;
	localparam int KEY_MAX     = 2**KEY_W - 1;
	localparam int DEPTH_W     = 10;
	localparam int TOTAL_W     = 20;
	localparam int TOTAL_OUT_W = 19;
	localparam int BIT_W       = 5;
	localparam int ROW_W       = 2**BIT_W;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	typedef struct packed {
		logic take_key;
		logic eval_own;
		logic eval_lo;
		logic eval_hi;
		logic eval_dlo;
		logic commit;
		logic reject;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ----- src/bstid_ctrl.sv -----
// Sequencer for one key insertion: row reads, depth reads, commit.
`default_nettype none
module bstid_ctrl
	import bstid_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_OWN  = 6'b000010,
		ST_LO   = 6'b000100,
		ST_HI   = 6'b001000,
		ST_DLO  = 6'b010000,
		ST_DHI  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_key = 1'b1;
					state_d      = ST_OWN;
				end
			end
			ST_OWN: begin
				if (sts.bad) begin
					if (sts.out_free) begin
						cmd.reject = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.eval_own = 1'b1;
					state_d      = ST_LO;
				end
			end
			ST_LO: begin
				cmd.eval_lo = 1'b1;
				state_d     = ST_HI;
			end
			ST_HI: begin
				cmd.eval_hi = 1'b1;
				state_d     = ST_DLO;
			end
			ST_DLO: begin
				cmd.eval_dlo = 1'b1;
				state_d      = ST_DHI;
			end
			ST_DHI: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ----- src/bstid_datapath.sv -----
// Presence rows, row summary, depth memory, running total and output register.
`default_nettype none
module bstid_datapath
	import bstid_pkg::*;
#(
	parameter int MAX_KEYS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [KEY_W-1:0]       key,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [DEPTH_W-1:0]     node_depth_out,
	output logic [TOTAL_OUT_W-1:0] depth_total,
	output logic                   rejected
);
	localparam int SLOTS = (MAX_KEYS < KEY_MAX) ? MAX_KEYS : KEY_MAX;
	localparam int SW    = ($clog2(SLOTS) > BIT_W) ? $clog2(SLOTS) : BIT_W + 1;
	localparam int RW    = SW - BIT_W;
	localparam int ROWS  = 2**RW;

	function automatic logic [BIT_W-1:0] word_msb(input logic [ROW_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < ROW_W; i++) begin
			if (w[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [BIT_W-1:0] word_lsb(input logic [ROW_W-1:0] w);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (w[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [RW-1:0] row_msb(input logic [ROWS-1:0] w);
		logic [RW-1:0] idx;
		idx = '0;
		for (int i = 0; i < ROWS; i++) begin
			if (w[i]) idx = RW'(i);
		end
		return idx;
	endfunction

	function automatic logic [RW-1:0] row_lsb(input logic [ROWS-1:0] w);
		logic [RW-1:0] idx;
		idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (w[i]) idx = RW'(i);
		end
		return idx;
	endfunction

	logic [KEY_W-1:0]       slot_full;
	logic                   oor_in;
	logic [SW-1:0]          slot_q;
	logic                   oor_q;
	logic [RW-1:0]          row;
	logic [BIT_W-1:0]       bitpos;
	logic [ROWS-1:0]        summary_q;
	logic [ROW_W-1:0]       pres_mem [ROWS];
	logic [ROW_W-1:0]       pres_rd_q;
	logic [RW-1:0]          pres_addr;
	logic                   pres_re;
	logic [DEPTH_W-1:0]     dep_mem [2**SW];
	logic [DEPTH_W-1:0]     dep_rd_q;
	logic [SW-1:0]          dep_addr;
	logic                   dep_re;
	logic [ROW_W-1:0]       bit_oh, below_mask, above_mask;
	logic [ROW_W-1:0]       own_word, own_lo, own_hi, own_q, lo_word, hi_word;
	logic [ROWS-1:0]        row_oh, row_below, row_above, sum_lo, sum_hi;
	logic [RW-1:0]          lo_row_d, hi_row_d, lo_row_q, hi_row_q;
	logic                   lo_same_q, hi_same_q, have_lo_q, have_hi_q;
	logic [SW-1:0]          lo_slot_q, hi_slot_q;
	logic [DEPTH_W-1:0]     lo_depth_q, hi_depth, dmax, new_depth;
	logic [DEPTH_W:0]       dinc;
	logic [TOTAL_W-1:0]     total_q, total_next, total_src;
	logic [TOTAL_W:0]       total_sum;
	logic                   out_valid_q, out_free;
	logic [DEPTH_W-1:0]     node_depth_q;
	logic [TOTAL_OUT_W-1:0] depth_total_q;
	logic                   rejected_q;

	assign slot_full = key - KEY_W'(1);
	assign oor_in    = (key == '0) || (int'(key) > MAX_KEYS);

	assign row    = slot_q[SW-1:BIT_W];
	assign bitpos = slot_q[BIT_W-1:0];

	assign bit_oh     = ROW_W'(1) << bitpos;
	assign below_mask = bit_oh - ROW_W'(1);
	assign above_mask = ~(below_mask | bit_oh);
	assign row_oh     = ROWS'(1) << row;
	assign row_below  = row_oh - ROWS'(1);
	assign row_above  = ~(row_below | row_oh);

	// a row with no summary bit was never written and reads as empty
	assign own_word = summary_q[row] ? pres_rd_q : '0;
	assign own_lo   = own_word & below_mask;
	assign own_hi   = own_word & above_mask;
	assign sum_lo   = summary_q & row_below;
	assign sum_hi   = summary_q & row_above;
	assign lo_row_d = (|own_lo) ? row : row_msb(sum_lo);
	assign hi_row_d = (|own_hi) ? row : row_lsb(sum_hi);
	assign lo_word  = pres_rd_q & (lo_same_q ? below_mask : '1);
	assign hi_word  = pres_rd_q & (hi_same_q ? above_mask : '1);

	assign out_free     = !out_valid_q || out_ready;
	assign sts.bad      = oor_q || (|(own_word & bit_oh));
	assign sts.out_free = out_free;

	always_comb begin
		if (cmd.take_key) begin
			pres_addr = slot_full[SW-1:BIT_W];
		end else if (cmd.eval_own) begin
			pres_addr = lo_row_d;
		end else begin
			pres_addr = hi_row_q;
		end
	end
	assign pres_re  = cmd.take_key || cmd.eval_own || cmd.eval_lo;
	assign dep_addr = cmd.eval_hi ? lo_slot_q : hi_slot_q;
	assign dep_re   = cmd.eval_hi || cmd.eval_dlo;

	assign hi_depth  = have_hi_q ? dep_rd_q : '0;
	assign dmax      = (lo_depth_q > hi_depth) ? lo_depth_q : hi_depth;
	assign dinc      = {1'b0, dmax} + (DEPTH_W+1)'(1);
	assign new_depth = !(have_lo_q || have_hi_q) ? '0 :
		(dinc[DEPTH_W] ? DEPTH_MAX : dinc[DEPTH_W-1:0]);

	assign total_sum  = {1'b0, total_q} + (TOTAL_W+1)'(new_depth);
	assign total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
	assign total_src  = cmd.commit ? total_next : total_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			pres_mem[row] <= own_q | bit_oh;
		end
		if (pres_re) begin
			pres_rd_q <= pres_mem[pres_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			dep_mem[slot_q] <= new_depth;
		end
		if (dep_re) begin
			dep_rd_q <= dep_mem[dep_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_key) begin
			slot_q <= slot_full[SW-1:0];
			oor_q  <= oor_in;
		end
		if (cmd.eval_own) begin
			own_q     <= own_word;
			lo_row_q  <= lo_row_d;
			hi_row_q  <= hi_row_d;
			lo_same_q <= |own_lo;
			hi_same_q <= |own_hi;
			have_lo_q <= (|own_lo) || (|sum_lo);
			have_hi_q <= (|own_hi) || (|sum_hi);
		end
		if (cmd.eval_lo) begin
			lo_slot_q <= {lo_row_q, word_msb(lo_word)};
		end
		if (cmd.eval_hi) begin
			hi_slot_q <= {hi_row_q, word_lsb(hi_word)};
		end
		if (cmd.eval_dlo) begin
			lo_depth_q <= have_lo_q ? dep_rd_q : '0;
		end
		if (cmd.commit || cmd.reject) begin
			node_depth_q  <= cmd.commit ? new_depth : '0;
			rejected_q    <= cmd.reject;
			depth_total_q <= (|total_src[TOTAL_W-1:TOTAL_OUT_W]) ? '1 :
				total_src[TOTAL_OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q   <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				summary_q <= summary_q | row_oh;
				total_q   <= total_next;
			end
			if (cmd.commit || cmd.reject) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign node_depth_out = node_depth_q;
	assign depth_total    = depth_total_q;
	assign rejected       = rejected_q;
endmodule
`default_nettype wire

// ----- src/bst_insert_depth_accumulator.sv -----
// Top level: insertion depth of keys in an unbalanced binary search tree.
//
//   channel  signals                                       direction
//   in       in_valid, in_ready, key                       into block
//   out      out_valid, out_ready, node_depth_out,
//            depth_total, rejected                         out of block
//
// An accepted key's result is registered after three reads of the presence
// rows (own, predecessor, successor row), then two reads of the depth memory;
// the next key may transfer the cycle after its commit. A rejected key's
// result is registered after the read of its own row alone, with no depth
// reads. Reset needs no clearing pass: a row summary
// flop marks each written row. A result waiting in the output register stalls
// the block just before its final write.
`default_nettype none
`include "bst_insert_depth_accumulator_macros.svh"
module bst_insert_depth_accumulator
	import bstid_pkg::*;
#(
	parameter int MAX_KEYS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [KEY_W-1:0]       key,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [DEPTH_W-1:0]     node_depth_out,
	output logic [TOTAL_OUT_W-1:0] depth_total,
	output logic                   rejected
);
	cmd_t cmd;
	sts_t sts;

	bstid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bstid_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.key            (key),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.node_depth_out (node_depth_out),
		.depth_total    (depth_total),
		.rejected       (rejected)
	);

	`BSTID_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "key transfer while busy")
	`BSTID_ASSERT_IMPL(a_result_slot_free, clk, arst_n, cmd.commit || cmd.reject, sts.out_free, "result overwrites pending output")
	`BSTID_ASSERT_IMPL(a_valid_source, clk, arst_n, $rose(out_valid), $past(cmd.commit || cmd.reject), "output valid without result")
	`BSTID_ASSERT_IMPL(a_reject_depth, clk, arst_n, out_valid && rejected, node_depth_out == '0, "rejected key with nonzero depth")
endmodule
`default_nettype wire
